// File: rtl/cnpd_pkg.sv
// Shared types, constants and the glitch decision for the cross-neighbor deglitcher.
// No dependencies; imported by the datapath top level and its port checker.
`default_nettype none

package cnpd_pkg;

   localparam int MAX_COLS    = 1024;
   localparam int MAX_ROWS    = 1024;
   localparam int PIX_W       = 8;
   localparam int COL_W       = $clog2(MAX_COLS);
   localparam int ROW_W       = $clog2(MAX_ROWS);
   localparam int SIZE_W      = 11;
   localparam int CSR_IDX_W   = 1;
   localparam int MAX_RESULTS = 3;
   localparam int FIFO_DEPTH  = 8;
   localparam int PTR_W       = $clog2(FIFO_DEPTH);
   localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
   localparam int REQ_DATA_W  = ((PIX_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = ROW_W + COL_W + PIX_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_USER_W  = 2;

   localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(30);
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(20);

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // Sum of up to four pixels, and a reciprocal of three good over its whole range
   localparam int SUM_W        = PIX_W + 2;
   localparam int RECIP3_SHIFT = SUM_W + 2;
   localparam int RECIP3       = (1 << RECIP3_SHIFT) / 3 + 1;
   localparam int PROD_W       = SUM_W + RECIP3_SHIFT;

   typedef logic [PIX_W-1:0] pix_type;

   typedef struct packed {
      pix_type value;
      logic    replaced;
   } judge_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      pix_type          value;
      logic             replaced;
      logic             frame_last;
      logic             run_last;
   } result_type;

   function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v, int hi);
      logic [SIZE_W-1:0] res;
      if (v < SIZE_W'(2)) begin
         res = SIZE_W'(2);
      end else if (v > SIZE_W'(hi)) begin
         res = SIZE_W'(hi);
      end else begin
         res = v;
      end
      return res;
   endfunction

   // Replace the center by the rounded-to-even mean of its valid neighbors when it
   // differs by more than one from every one of them.
   function automatic judge_type judge(pix_type center, pix_type [3:0] nb, logic [3:0] vld);
      logic [SUM_W-1:0]  sum;
      logic [2:0]        k;
      logic              all_far;
      pix_type           diff;
      logic [PROD_W-1:0] prod;
      logic [SUM_W-1:0]  q;
      logic [SUM_W-1:0]  tmp;
      logic              up;
      judge_type         res;
      sum     = '0;
      k       = '0;
      all_far = 1'b1;
      prod    = '0;
      tmp     = '0;
      for (int i = 0; i < 4; i++) begin
         diff = (center > nb[i]) ? (center - nb[i]) : (nb[i] - center);
         if (vld[i]) begin
            sum = sum + SUM_W'(nb[i]);
            k   = k + 3'd1;
            if (diff <= PIX_W'(1)) all_far = 1'b0;
         end
      end
      unique case (k)
         3'd2: begin
            q  = sum >> 1;
            up = sum[0] & q[0];
         end
         3'd3: begin
            prod = PROD_W'(sum) * PROD_W'(RECIP3);
            q    = SUM_W'(prod >> RECIP3_SHIFT);
            tmp  = sum - SUM_W'(q + (q << 1));
            up   = (tmp[1:0] == 2'd2);
         end
         3'd4: begin
            q  = sum >> 2;
            up = (sum[1:0] == 2'd3) || ((sum[1:0] == 2'd2) && q[0]);
         end
         default: begin
            q  = SUM_W'(center);
            up = 1'b0;
         end
      endcase
      res.replaced = all_far;
      res.value    = all_far ? PIX_W'(q + SUM_W'(up)) : center;
      return res;
   endfunction

endpackage

`default_nettype wire

// File: rtl/cross_neighbour_pixel_deglitch.sv
// Top level of the cross-neighbor deglitcher: line memories, decision stage, result FIFO.
// Depends on cnpd_pkg for types, constants and the judge function.
`default_nettype none

// Impulse-noise filter for a raster stream. Each pixel is compared with its edge
// neighbors (corrected above and left, raw right and below) and replaced by their
// rounded-to-even mean when it is more than one away from all of them. Pixel (r,c)
// leaves when raw (r+1,c) arrives; the last row leaves with its own inputs, so a
// transaction on req yields zero to three rsp transactions, the last one flagged by
// rsp_tlast. Outside the last row one pixel is taken every cycle while the result FIFO
// has room, each result passing the second-stage registers and the FIFO; in the last
// row the single result port, draining the eight-entry FIFO one transaction a cycle
// while rsp_tready is high, holds intake back. Two line memories (raw pending row and
// corrected row above), each with one read and one write per cycle, are read ahead
// (corrected row at the next column, raw row one further), so pixels need no stall;
// they need no clearing after reset, and a csr write restarts the frame at row 0, col 0.
module cross_neighbour_pixel_deglitch
   import cnpd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // [7:0] pixel_value
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,  // [9:0] out_row, [19:10] out_col,
                                                  // [27:20] out_value, rest zero
   output      logic                  rsp_tlast,  // run_last
   output      logic [RSP_USER_W-1:0] rsp_tuser,  // [0] was_replaced, [1] frame_last
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [SIZE_W-1:0]     csr_wdata
);

   // Configuration and position
   logic [SIZE_W-1:0] width_ff, height_ff;
   logic [SIZE_W-1:0] width_cl, height_cl;
   logic [COL_W-1:0]  last_col;
   logic [ROW_W-1:0]  last_row;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              col_end, row_end;
   logic              accept;
   pix_type           px;

   // Line memories and their read registers
   pix_type           pend_mem [MAX_COLS];
   pix_type           corr_mem [MAX_COLS];
   pix_type           pend_rd_ff, corr_rd_ff;
   logic [COL_W-1:0]  pend_rd_addr;
   logic              right_byp_ff, right_byp_in;
   pix_type           right_val;

   // Neighborhood registers
   pix_type           cur_ff, cur_in;
   pix_type           first_ff;
   pix_type           prev_px_ff;
   pix_type           left_corr_ff, left_corr_in;
   pix_type           left_last_ff, left_last_in;

   // Decisions at the input
   logic              has_a, has_b, has_c;
   judge_type         a_res, b_res, c_res;

   // Second stage
   logic              s1_valid_ff;
   logic              s1_a_ff, s1_b_ff, s1_c_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic [COL_W-1:0]  s1_col_ff;
   pix_type           s1_px_ff;
   judge_type         s1_a_res_ff, s1_b_res_ff;
   result_type        ent_a, ent_b, ent_c;
   result_type        pk [MAX_RESULTS];
   logic [1:0]        slot;
   logic [1:0]        n_push;

   // Result FIFO
   result_type        fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  reserve;
   logic              pop;
   result_type        head;

   assign width_cl  = clamp_size(width_ff, MAX_COLS);
   assign height_cl = clamp_size(height_ff, MAX_ROWS);
   assign last_col  = COL_W'(width_cl - SIZE_W'(1));
   assign last_row  = ROW_W'(height_cl - SIZE_W'(1));

   assign px      = req_tdata[PIX_W-1:0];
   assign accept  = req_tvalid & req_tready;
   assign col_end = (col_ff == last_col);
   assign row_end = (row_ff == last_row);

   always_comb begin
      if (col_end) begin
         col_in = '0;
         row_in = row_end ? '0 : row_ff + ROW_W'(1);
      end else begin
         col_in = col_ff + COL_W'(1);
         row_in = row_ff;
      end
   end

   // Fetch the right neighbor of the next position; take it from the input when that
   // entry is being written by this very transaction.
   assign pend_rd_addr = col_in + COL_W'(1);
   assign right_byp_in = (pend_rd_addr == col_ff);
   assign right_val    = right_byp_ff ? prev_px_ff : pend_rd_ff;
   assign cur_in       = col_end ? first_ff : right_val;

   assign has_a = (row_ff != '0);
   assign has_b = row_end && (col_ff != '0);
   assign has_c = row_end && col_end;

   // Emit the row above: corrected above, corrected left, raw right, raw below
   assign a_res = judge(cur_ff, {px, right_val, left_corr_ff, corr_rd_ff},
                        {1'b1, !col_end, col_ff != '0, row_ff > ROW_W'(1)});
   // Emit the left pixel of the last row; its upper neighbor was decided one column ago
   assign b_res = judge(prev_px_ff, {px, px, left_last_ff, left_corr_ff},
                        {1'b0, 1'b1, col_ff > COL_W'(1), 1'b1});

   assign left_corr_in = has_a ? a_res.value : left_corr_ff;
   assign left_last_in = has_b ? b_res.value : left_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         left_corr_ff <= '0;
         left_last_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_ff  <= csr_wdata;
            CSR_FRAME_HEIGHT: height_ff <= csr_wdata;
         endcase
         row_ff       <= '0;
         col_ff       <= '0;
         left_corr_ff <= '0;
         left_last_ff <= '0;
      end else if (accept) begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         left_corr_ff <= left_corr_in;
         left_last_ff <= left_last_in;
      end
   end

   // Line memories: write this column, read the next column (corrected) and the one after (raw)
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_mem[col_ff] <= px;
         if (has_a) corr_mem[col_ff] <= a_res.value;
         pend_rd_ff <= pend_mem[pend_rd_addr];
         corr_rd_ff <= corr_mem[col_in];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         right_byp_ff <= right_byp_in;
         cur_ff       <= cur_in;
         prev_px_ff   <= px;
         if (col_ff == '0) first_ff <= px;
         s1_a_ff      <= has_a;
         s1_b_ff      <= has_b;
         s1_c_ff      <= has_c;
         s1_row_ff    <= row_ff;
         s1_col_ff    <= col_ff;
         s1_px_ff     <= px;
         s1_a_res_ff  <= a_res;
         s1_b_res_ff  <= b_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   // Final pixel of the frame: its upper and left neighbors are both decided by
   // the previous stage.
   assign c_res = judge(s1_px_ff, {s1_px_ff, s1_px_ff, s1_b_res_ff.value, s1_a_res_ff.value},
                        4'b0011);

   always_comb begin
      ent_a.row        = s1_row_ff - ROW_W'(1);
      ent_a.col        = s1_col_ff;
      ent_a.value      = s1_a_res_ff.value;
      ent_a.replaced   = s1_a_res_ff.replaced;
      ent_a.frame_last = 1'b0;
      ent_a.run_last   = !s1_b_ff && !s1_c_ff;
      ent_b.row        = s1_row_ff;
      ent_b.col        = s1_col_ff - COL_W'(1);
      ent_b.value      = s1_b_res_ff.value;
      ent_b.replaced   = s1_b_res_ff.replaced;
      ent_b.frame_last = 1'b0;
      ent_b.run_last   = !s1_c_ff;
      ent_c.row        = s1_row_ff;
      ent_c.col        = s1_col_ff;
      ent_c.value      = c_res.value;
      ent_c.replaced   = c_res.replaced;
      ent_c.frame_last = 1'b1;
      ent_c.run_last   = 1'b1;
   end

   // Pack the results of one transaction into consecutive FIFO slots
   always_comb begin
      for (int j = 0; j < MAX_RESULTS; j++) pk[j] = ent_c;
      slot = '0;
      if (s1_a_ff) begin
         pk[slot] = ent_a;
         slot     = slot + 2'd1;
      end
      if (s1_b_ff) begin
         pk[slot] = ent_b;
         slot     = slot + 2'd1;
      end
      if (s1_c_ff) begin
         pk[slot] = ent_c;
         slot     = slot + 2'd1;
      end
      n_push = s1_valid_ff ? slot : 2'd0;
   end

   assign head       = fifo_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign pop        = rsp_tvalid & rsp_tready;
   assign count_in   = count_ff + CNT_W'(n_push) - CNT_W'(pop);

   // Reserve room for the transaction in the second stage and for the next one
   assign reserve    = s1_valid_ff ? CNT_W'(2 * MAX_RESULTS) : CNT_W'(MAX_RESULTS);
   assign req_tready = (count_ff <= CNT_W'(FIFO_DEPTH) - reserve);

   always_ff @(posedge clock) begin
      for (int j = 0; j < MAX_RESULTS; j++) begin
         if (2'(j) < n_push) fifo_ff[wr_ptr_ff + PTR_W'(j)] <= pk[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(n_push);
         rd_ptr_ff <= rd_ptr_ff + PTR_W'(pop);
         count_ff  <= count_in;
      end
   end

   assign rsp_tdata = RSP_DATA_W'({head.value, head.col, head.row});
   assign rsp_tlast = head.run_last;
   assign rsp_tuser = {head.frame_last, head.replaced};

endmodule

`default_nettype wire

// File: rtl/cnpd_checker.sv
// Port-level checker for the cross-neighbor deglitcher, bound to its top level.
// Depends on cnpd_pkg for port widths.
`default_nettype none

module cnpd_checker
   import cnpd_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tlast,
   input wire logic [RSP_USER_W-1:0] rsp_tuser
);

   // A waiting result transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp transaction changed while stalled");

   // Nothing is pending right after reset
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // The frame's final pixel closes its run
   a_frame_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("frame_last without run_last");

   // The final pixel sits past the first row and column
   a_frame_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> (rsp_tdata[ROW_W-1:0] != '0)
                                     && (rsp_tdata[ROW_W+COL_W-1:ROW_W] != '0))
      else $error("frame_last on a first-row or first-column pixel");

endmodule

bind cross_neighbour_pixel_deglitch cnpd_checker u_cnpd_checker (.*);

`default_nettype wire
